/* rtl/sstf_pkg.sv */
package sstf_pkg;

   localparam int YEAR_W   = 16;
   localparam int VALUE_W  = 32;
   localparam int ENTRY_W  = YEAR_W + VALUE_W;
   localparam int ICPT_W   = 48;
   localparam int COUNT_W  = 7;
   localparam logic signed [VALUE_W-1:0] MISSING_MARK = -32'sd65536;

   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_MISSING   = 3'd1,
      STAT_DUP       = 3'd2,
      STAT_NOT_FOUND = 3'd3,
      STAT_FULL      = 3'd4
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE, S_SRCH_RD, S_SRCH_CMP, S_DECIDE, S_UP_RD, S_UP_WR, S_INS,
      S_DN_RD, S_DN_WR, S_UPD, S_SUM_INIT, S_SUM_RD, S_SUM_MUL, S_SUM_ACC,
      S_FIN_MUL, S_FIN_SUB, S_MEAN_GO, S_MEAN_WAIT, S_SLOPE_GO, S_SLOPE_WAIT,
      S_ICPT_MUL, S_ICPT_GO, S_ICPT_WAIT, S_OUT
   } ctrl_state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_ACCEPT, OP_SRCH_RD, OP_SRCH_CMP, OP_DECIDE, OP_UP_RD,
      OP_UP_WR, OP_INS, OP_DN_RD, OP_DN_WR, OP_UPD, OP_SUM_INIT, OP_SUM_RD,
      OP_SUM_MUL, OP_SUM_ACC, OP_MEAN_GO, OP_MEAN_DONE, OP_SLOPE_GO,
      OP_SLOPE_DONE, OP_ICPT_GO, OP_ICPT_DONE, OP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      status_type code;
   } dp_cmd_type;

   typedef struct packed {
      logic kind;
      logic missing;
      logic found;
      logic full;
      logic empty;
      logic scan_end;
      logic hit;
      logic up_done;
      logic dn_done;
      logic fit_ok;
      logic div_busy;
      logic rsp_busy;
   } dp_stat_type;

endpackage

/* rtl/sstf_if.sv */
interface sstf_req_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic [15:0]        year;
   logic signed [31:0] value;

   modport source(output valid, kind, year, value, input ready);
   modport sink(input valid, kind, year, value, output ready);
endinterface

interface sstf_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic [6:0]         entry_count;
   logic               stats_valid;
   logic signed [31:0] avg_value;
   logic               is_monotone;
   logic               fit_valid;
   logic signed [31:0] slope;
   logic signed [47:0] intercept;

   modport source(output valid, status, entry_count, stats_valid, avg_value,
                  is_monotone, fit_valid, slope, intercept, input ready);
   modport sink(input valid, status, entry_count, stats_valid, avg_value,
                is_monotone, fit_valid, slope, intercept, output ready);
endinterface

/* rtl/sstf_ram.sv */
module sstf_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* rtl/sstf_div.sv */
module sstf_div #(
   parameter int MW = 62,
   parameter int DW = 46
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [MW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          busy,
   output logic [MW-1:0] quot
);
   localparam int CNTW = $clog2(MW + 1);

   logic            busy_ff, busy_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]   rem_ff, rem_in;
   logic [DW-1:0]   den_ff, den_in;
   logic [MW-1:0]   q_ff, q_in;
   logic [DW:0]     rem_sh;
   logic [DW+1:0]   diff;
   logic            ge;

   assign rem_sh = {rem_ff, q_ff[MW-1]};
   assign diff   = {1'b0, rem_sh} - {2'b00, den_ff};
   assign ge     = ~diff[DW+1];

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNTW'(MW);
         rem_in  = '0;
         den_in  = den;
         q_in    = num;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
         q_in   = {q_ff[MW-2:0], ge};
         cnt_in = cnt_ff - CNTW'(1);
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign busy = busy_ff;
   assign quot = q_ff;
endmodule

/* rtl/sstf_ctrl.sv */
module sstf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sstf_pkg::dp_stat_type stat,
   output sstf_pkg::dp_cmd_type  cmd
);
   import sstf_pkg::*;

   ctrl_state_type state_ff, state_in;
   status_type     decide_code;

   always_comb begin
      if (!stat.kind) begin
         if (stat.missing) begin
            decide_code = STAT_MISSING;
         end else if (stat.found) begin
            decide_code = STAT_DUP;
         end else if (stat.full) begin
            decide_code = STAT_FULL;
         end else begin
            decide_code = STAT_OK;
         end
      end else begin
         decide_code = stat.found ? STAT_OK : STAT_NOT_FOUND;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:       if (req_valid) state_in = S_SRCH_RD;
         S_SRCH_RD:    state_in = stat.scan_end ? S_DECIDE : S_SRCH_CMP;
         S_SRCH_CMP:   state_in = stat.hit ? S_DECIDE : S_SRCH_RD;
         S_DECIDE: begin
            if (decide_code != STAT_OK) begin
               state_in = S_SUM_INIT;
            end else if (!stat.kind) begin
               state_in = S_UP_RD;
            end else begin
               state_in = stat.missing ? S_DN_RD : S_UPD;
            end
         end
         S_UP_RD:      state_in = stat.up_done ? S_INS : S_UP_WR;
         S_UP_WR:      state_in = S_UP_RD;
         S_INS:        state_in = S_SUM_INIT;
         S_DN_RD:      state_in = stat.dn_done ? S_SUM_INIT : S_DN_WR;
         S_DN_WR:      state_in = S_DN_RD;
         S_UPD:        state_in = S_SUM_INIT;
         S_SUM_INIT:   state_in = S_SUM_RD;
         S_SUM_RD:     state_in = stat.scan_end ? S_FIN_MUL : S_SUM_MUL;
         S_SUM_MUL:    state_in = S_SUM_ACC;
         S_SUM_ACC:    state_in = S_SUM_RD;
         S_FIN_MUL:    state_in = S_FIN_SUB;
         S_FIN_SUB:    state_in = stat.empty ? S_OUT : S_MEAN_GO;
         S_MEAN_GO:    state_in = S_MEAN_WAIT;
         S_MEAN_WAIT: begin
            if (!stat.div_busy) state_in = stat.fit_ok ? S_SLOPE_GO : S_OUT;
         end
         S_SLOPE_GO:   state_in = S_SLOPE_WAIT;
         S_SLOPE_WAIT: if (!stat.div_busy) state_in = S_ICPT_MUL;
         S_ICPT_MUL:   state_in = S_ICPT_GO;
         S_ICPT_GO:    state_in = S_ICPT_WAIT;
         S_ICPT_WAIT:  if (!stat.div_busy) state_in = S_OUT;
         S_OUT:        if (!stat.rsp_busy) state_in = S_IDLE;
         default:      state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd.op    = OP_NONE;
      cmd.code  = decide_code;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = OP_ACCEPT;
         end
         S_SRCH_RD:    cmd.op = OP_SRCH_RD;
         S_SRCH_CMP:   cmd.op = OP_SRCH_CMP;
         S_DECIDE:     cmd.op = OP_DECIDE;
         S_UP_RD:      cmd.op = OP_UP_RD;
         S_UP_WR:      cmd.op = OP_UP_WR;
         S_INS:        cmd.op = OP_INS;
         S_DN_RD:      cmd.op = OP_DN_RD;
         S_DN_WR:      cmd.op = OP_DN_WR;
         S_UPD:        cmd.op = OP_UPD;
         S_SUM_INIT:   cmd.op = OP_SUM_INIT;
         S_SUM_RD:     cmd.op = OP_SUM_RD;
         S_SUM_MUL:    cmd.op = OP_SUM_MUL;
         S_SUM_ACC:    cmd.op = OP_SUM_ACC;
         S_MEAN_GO:    cmd.op = OP_MEAN_GO;
         S_MEAN_WAIT:  if (!stat.div_busy) cmd.op = OP_MEAN_DONE;
         S_SLOPE_GO:   cmd.op = OP_SLOPE_GO;
         S_SLOPE_WAIT: if (!stat.div_busy) cmd.op = OP_SLOPE_DONE;
         S_ICPT_GO:    cmd.op = OP_ICPT_GO;
         S_ICPT_WAIT:  if (!stat.div_busy) cmd.op = OP_ICPT_DONE;
         S_OUT:        if (!stat.rsp_busy) cmd.op = OP_OUT;
         default:      cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

/* rtl/sstf_dp.sv */
module sstf_dp #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sstf_pkg::dp_cmd_type  cmd,
   output sstf_pkg::dp_stat_type stat,
   input  logic                  req_kind,
   input  logic [15:0]           req_year,
   input  logic signed [31:0]    req_value,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [2:0]            rsp_status,
   output logic [6:0]            rsp_entry_count,
   output logic                  rsp_stats_valid,
   output logic signed [31:0]    rsp_avg_value,
   output logic                  rsp_is_monotone,
   output logic                  rsp_fit_valid,
   output logic signed [31:0]    rsp_slope,
   output logic signed [47:0]    rsp_intercept
);
   import sstf_pkg::*;

   localparam int AW    = $clog2(TABLE_DEPTH);
   localparam int CW    = $clog2(TABLE_DEPTH + 1);
   localparam int SXW   = 16 + CW;
   localparam int SVW   = 32 + CW;
   localparam int SXXW  = 32 + CW;
   localparam int SXVW  = 49 + CW;
   localparam int DW    = 32 + 2 * CW;
   localparam int MW    = 48 + 2 * CW;
   localparam int NUMW  = MW + 1;
   localparam int PW    = 49 + CW;
   localparam int TW    = 50 + CW;

   logic               kind_ff, kind_in;
   logic [15:0]        year_ff, year_in;
   logic signed [31:0] value_ff, value_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      idx_ff, idx_in, idx_m1, idx_p1;
   logic [CW-1:0]      pos_ff, pos_in;
   logic               found_ff, found_in;
   status_type         code_ff, code_in;

   logic [15:0]        x_ff;
   logic signed [31:0] v_ff;
   logic [31:0]        xx_ff;
   logic signed [48:0] xv_ff;
   logic signed [31:0] prev_ff, prev_in;
   logic               up_ff, up_in, down_ff, down_in;
   logic [SXW-1:0]         sx_ff, sx_in;
   logic signed [SVW-1:0]  sv_ff, sv_in;
   logic [SXXW-1:0]        sxx_ff, sxx_in;
   logic signed [SXVW-1:0] sxv_ff, sxv_in;
   logic [DW-1:0]          p1_ff, p2_ff, den_ff;
   logic signed [NUMW-1:0] p3_ff, p4_ff, num_ff;
   logic signed [PW-1:0]   prod_ff;
   logic                   neg_ff, neg_in;
   logic signed [31:0]     mean_ff, mean_in, slope_ff, slope_in;
   logic signed [47:0]     icpt_ff, icpt_in;
   logic                   fitv_ff, fitv_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_status_ff;
   logic [6:0]         rsp_count_ff;
   logic               rsp_sv_ff, rsp_mono_ff, rsp_fitv_ff;
   logic signed [31:0] rsp_mean_ff, rsp_slope_ff;
   logic signed [47:0] rsp_icpt_ff;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr, ram_raddr;
   logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
   logic [15:0]        rd_year;
   logic signed [31:0] rd_value;

   logic               div_start, div_busy;
   logic [MW-1:0]      div_num, div_quot;
   logic [DW-1:0]      div_den;
   logic [SVW-1:0]     sv_mag;
   logic [NUMW-1:0]    num_mag;
   logic signed [TW-1:0] t_val;
   logic [TW-1:0]      t_mag;
   logic [31:0]        q32, slope_sat;
   logic [47:0]        icpt_sat;
   logic               mono;

   sstf_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock(clock), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
      .raddr(ram_raddr), .rdata(ram_rdata)
   );

   sstf_div #(.MW(MW), .DW(DW)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num),
      .den(div_den), .busy(div_busy), .quot(div_quot)
   );

   assign rd_year  = ram_rdata[ENTRY_W-1:VALUE_W];
   assign rd_value = $signed(ram_rdata[VALUE_W-1:0]);
   assign idx_m1   = idx_ff - CW'(1);
   assign idx_p1   = idx_ff + CW'(1);
   assign sv_mag   = sv_ff[SVW-1] ? SVW'(-sv_ff) : SVW'(sv_ff);
   assign num_mag  = num_ff[NUMW-1] ? NUMW'(-num_ff) : NUMW'(num_ff);
   assign t_val    = TW'(sv_ff) - TW'(prod_ff);
   assign t_mag    = t_val[TW-1] ? TW'(-t_val) : TW'(t_val);
   assign q32      = div_quot[31:0];

   always_comb begin
      if (!neg_ff) begin
         slope_sat = (div_quot > MW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q32;
         icpt_sat  = (div_quot > MW'(48'h7FFF_FFFF_FFFF)) ? 48'h7FFF_FFFF_FFFF
                                                          : div_quot[47:0];
      end else begin
         slope_sat = (div_quot > MW'(33'h0_8000_0000)) ? 32'h8000_0000
                                                       : 32'd0 - q32;
         icpt_sat  = (div_quot > MW'(49'h0_8000_0000_0000)) ? 48'h8000_0000_0000
                                                            : 48'd0 - div_quot[47:0];
      end
   end

   assign mono = (count_ff != '0) && (up_ff || down_ff);

   assign stat.kind     = kind_ff;
   assign stat.missing  = (value_ff == MISSING_MARK);
   assign stat.found    = found_ff;
   assign stat.full     = (count_ff == CW'(TABLE_DEPTH));
   assign stat.empty    = (count_ff == '0);
   assign stat.scan_end = (idx_ff == count_ff);
   assign stat.hit      = (rd_year >= year_ff);
   assign stat.up_done  = (idx_ff == pos_ff);
   assign stat.dn_done  = (idx_p1 >= count_ff);
   assign stat.fit_ok   = (count_ff >= CW'(2)) && (den_ff != '0);
   assign stat.div_busy = div_busy;
   assign stat.rsp_busy = rsp_valid_ff && !rsp_ready;

   always_comb begin
      kind_in   = kind_ff;
      year_in   = year_ff;
      value_in  = value_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      found_in  = found_ff;
      code_in   = code_ff;
      prev_in   = prev_ff;
      up_in     = up_ff;
      down_in   = down_ff;
      sx_in     = sx_ff;
      sv_in     = sv_ff;
      sxx_in    = sxx_ff;
      sxv_in    = sxv_ff;
      neg_in    = neg_ff;
      mean_in   = mean_ff;
      slope_in  = slope_ff;
      icpt_in   = icpt_ff;
      fitv_in   = fitv_ff;
      ram_we    = 1'b0;
      ram_waddr = idx_ff[AW-1:0];
      ram_wdata = {year_ff, value_ff};
      ram_raddr = idx_ff[AW-1:0];
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (cmd.op)
         OP_ACCEPT: begin
            kind_in  = req_kind;
            year_in  = req_year;
            value_in = req_value;
            idx_in   = '0;
            found_in = 1'b0;
            pos_in   = count_ff;
         end
         OP_SRCH_CMP: begin
            if (rd_year >= year_ff) begin
               pos_in   = idx_ff;
               found_in = (rd_year == year_ff);
            end else begin
               idx_in = idx_p1;
            end
         end
         OP_DECIDE: begin
            code_in = cmd.code;
            idx_in  = kind_ff ? pos_ff : count_ff;
         end
         OP_UP_RD: ram_raddr = idx_m1[AW-1:0];
         OP_UP_WR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            idx_in    = idx_m1;
         end
         OP_INS: begin
            ram_we    = 1'b1;
            ram_waddr = pos_ff[AW-1:0];
            count_in  = count_ff + CW'(1);
         end
         OP_DN_RD: begin
            if (idx_p1 >= count_ff) begin
               count_in = count_ff - CW'(1);
            end else begin
               ram_raddr = idx_p1[AW-1:0];
            end
         end
         OP_DN_WR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            idx_in    = idx_p1;
         end
         OP_UPD: begin
            ram_we    = 1'b1;
            ram_waddr = pos_ff[AW-1:0];
         end
         OP_SUM_INIT: begin
            idx_in   = '0;
            sx_in    = '0;
            sv_in    = '0;
            sxx_in   = '0;
            sxv_in   = '0;
            up_in    = 1'b1;
            down_in  = 1'b1;
            mean_in  = '0;
            slope_in = '0;
            icpt_in  = '0;
            fitv_in  = 1'b0;
         end
         OP_SUM_MUL: begin
            if (idx_ff != '0) begin
               if (rd_value > prev_ff) down_in = 1'b0;
               if (rd_value < prev_ff) up_in = 1'b0;
            end
            prev_in = rd_value;
         end
         OP_SUM_ACC: begin
            sx_in  = sx_ff + SXW'(x_ff);
            sv_in  = sv_ff + SVW'(v_ff);
            sxx_in = sxx_ff + SXXW'(xx_ff);
            sxv_in = sxv_ff + SXVW'(xv_ff);
            idx_in = idx_p1;
         end
         OP_MEAN_GO: begin
            div_start = 1'b1;
            div_num   = MW'(sv_mag);
            div_den   = DW'(count_ff);
            neg_in    = sv_ff[SVW-1];
         end
         OP_MEAN_DONE: mean_in = neg_ff ? $signed(32'd0 - q32) : $signed(q32);
         OP_SLOPE_GO: begin
            div_start = 1'b1;
            div_num   = MW'(num_mag);
            div_den   = den_ff;
            neg_in    = num_ff[NUMW-1];
         end
         OP_SLOPE_DONE: begin
            slope_in = $signed(slope_sat);
            fitv_in  = 1'b1;
         end
         OP_ICPT_GO: begin
            div_start = 1'b1;
            div_num   = MW'(t_mag);
            div_den   = DW'(count_ff);
            neg_in    = t_val[TW-1];
         end
         OP_ICPT_DONE: icpt_in = $signed(icpt_sat);
         OP_OUT: rsp_valid_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff  <= kind_in;
      year_ff  <= year_in;
      value_ff <= value_in;
      idx_ff   <= idx_in;
      pos_ff   <= pos_in;
      found_ff <= found_in;
      code_ff  <= code_in;
      x_ff     <= rd_year;
      v_ff     <= rd_value;
      xx_ff    <= rd_year * rd_year;
      xv_ff    <= $signed({1'b0, rd_year}) * rd_value;
      prev_ff  <= prev_in;
      up_ff    <= up_in;
      down_ff  <= down_in;
      sx_ff    <= sx_in;
      sv_ff    <= sv_in;
      sxx_ff   <= sxx_in;
      sxv_ff   <= sxv_in;
      p1_ff    <= count_ff * sxx_ff;
      p2_ff    <= sx_ff * sx_ff;
      p3_ff    <= $signed({1'b0, count_ff}) * sxv_ff;
      p4_ff    <= $signed({1'b0, sx_ff}) * sv_ff;
      den_ff   <= p1_ff - p2_ff;
      num_ff   <= p3_ff - p4_ff;
      prod_ff  <= slope_ff * $signed({1'b0, sx_ff});
      neg_ff   <= neg_in;
      mean_ff  <= mean_in;
      slope_ff <= slope_in;
      icpt_ff  <= icpt_in;
      fitv_ff  <= fitv_in;
      if (cmd.op == OP_OUT) begin
         rsp_status_ff <= code_ff;
         rsp_count_ff  <= COUNT_W'(count_ff);
         rsp_sv_ff     <= (count_ff != '0);
         rsp_mean_ff   <= mean_ff;
         rsp_mono_ff   <= mono;
         rsp_fitv_ff   <= fitv_ff;
         rsp_slope_ff  <= slope_ff;
         rsp_icpt_ff   <= icpt_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_stats_valid = rsp_sv_ff;
   assign rsp_avg_value   = rsp_mean_ff;
   assign rsp_is_monotone = rsp_mono_ff;
   assign rsp_fit_valid   = rsp_fitv_ff;
   assign rsp_slope       = rsp_slope_ff;
   assign rsp_intercept   = rsp_icpt_ff;
endmodule

/* rtl/sorted_series_table_with_fit.sv */
// Sorted table of (year, value) entries with running statistics and a line fit.
// The req channel carries one word per operation: kind 0 adds a year, kind 1
// replaces its value or removes it when the value is the missing marker -1.0.
// The rsp channel returns one word per request with the status, entry count,
// mean, monotone flag and the least-squares slope and intercept.
// Entries live in one single-port-read RAM, so the search, the shift and the
// statistics pass each walk the table one entry at a time. The three
// divisions share one restoring divider that produces one quotient bit a cycle.
// A new request is taken only once the previous one has been computed; a
// finished response waits in the output register, so a stalled receiver holds
// back at most the next response, never the next request.
// Reset empties the table at once; stored entries need no clearing.
module sorted_series_table_with_fit #(
   parameter int TABLE_DEPTH = 64
) (
   input logic        clock,
   input logic        reset,
   sstf_req_if.sink   req_chan,
   sstf_rsp_if.source rsp_chan
);
   import sstf_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   sstf_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_chan.valid),
      .req_ready(req_chan.ready), .stat(stat), .cmd(cmd)
   );

   sstf_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_kind(req_chan.kind), .req_year(req_chan.year),
      .req_value(req_chan.value), .rsp_ready(rsp_chan.ready),
      .rsp_valid(rsp_chan.valid), .rsp_status(rsp_chan.status),
      .rsp_entry_count(rsp_chan.entry_count),
      .rsp_stats_valid(rsp_chan.stats_valid),
      .rsp_avg_value(rsp_chan.avg_value),
      .rsp_is_monotone(rsp_chan.is_monotone),
      .rsp_fit_valid(rsp_chan.fit_valid), .rsp_slope(rsp_chan.slope),
      .rsp_intercept(rsp_chan.intercept)
   );

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted while a request is in progress");

   a_load_on_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(cmd.op == OP_OUT))
      else $error("response appeared without an output load");

   a_fit_needs_stats: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> ((rsp_chan.stats_valid == (rsp_chan.entry_count != 7'd0))
                          && (!rsp_chan.fit_valid || rsp_chan.stats_valid)))
      else $error("response flags disagree with entry count");
`endif
endmodule

/* tb/sv/sorted_series_table_with_fit_tb.sv */
module sorted_series_table_with_fit_tb;
   import sstf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 64;
   localparam int ITEM_TARGET = 1400;
   localparam int IDLE_LIMIT = 20000;
   localparam int HOLD_CYCLES = 2000;
   localparam int DRAIN_CYCLES = 700;
   localparam int ROW_COUNT = 22;

   typedef struct {
      logic [2:0]         status;
      logic [6:0]         entry_count;
      logic               stats_valid;
      logic signed [31:0] avg_value;
      logic               is_monotone;
      logic               fit_valid;
      logic signed [31:0] slope;
      logic signed [47:0] intercept;
   } table_report_type;

   typedef struct {
      bit         kind;
      int         year;
      int         value;
      bit         typed;
      logic [2:0] status;
      int         entry_count;
   } stim_row_type;

   logic clock;
   logic reset;

   sstf_req_if req_chan();
   sstf_rsp_if rsp_chan();

   sorted_series_table_with_fit #(.TABLE_DEPTH(DEPTH)) uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   int               shadow_years[DEPTH];
   int               shadow_values[DEPTH];
   int               shadow_count;
   table_report_type pending_reports[$];
   int               mismatch_count;
   int               words_sent;
   int               words_checked;
   int               status_seen[5];
   int               fill_peak;
   int               idle_cycles;
   bit               hold_rsp;
   int               stall_left;

   stim_row_type stim_rows[ROW_COUNT] = '{
      '{1, 5, 0, 1, STAT_NOT_FOUND, 0},
      '{0, 100, int'(MISSING_MARK), 1, STAT_MISSING, 0},
      '{0, 0, 32'h7fff_ffff, 1, STAT_OK, 1},
      '{0, 65535, 32'h8000_0000, 1, STAT_OK, 2},
      '{0, 0, 7, 1, STAT_DUP, 2},
      '{0, 300, 65536, 1, STAT_OK, 3},
      '{1, 300, int'(MISSING_MARK), 1, STAT_OK, 2},
      '{1, 300, 1, 1, STAT_NOT_FOUND, 2},
      '{1, 0, 32'h8000_0000, 0, STAT_OK, 0},
      '{1, 65535, 32'h7fff_ffff, 0, STAT_OK, 0},
      '{0, 1, 100, 0, STAT_OK, 0},
      '{0, 2, 100, 0, STAT_OK, 0},
      '{0, 3, -200, 0, STAT_OK, 0},
      '{0, 32768, 0, 0, STAT_OK, 0},
      '{1, 2, 50, 0, STAT_OK, 0},
      '{1, 0, int'(MISSING_MARK), 1, STAT_OK, 5},
      '{1, 1, int'(MISSING_MARK), 1, STAT_OK, 4},
      '{1, 2, int'(MISSING_MARK), 1, STAT_OK, 3},
      '{1, 3, int'(MISSING_MARK), 1, STAT_OK, 2},
      '{1, 32768, int'(MISSING_MARK), 1, STAT_OK, 1},
      '{1, 65535, int'(MISSING_MARK), 1, STAT_OK, 0},
      '{1, 65535, 3, 1, STAT_NOT_FOUND, 0}
   };

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int find_year(int yr);
      for (int i = 0; i < shadow_count; i++)
         if (shadow_years[i] == yr) return i;
      return -1;
   endfunction

   function automatic table_report_type apply_word(bit kind, int yr, int val);
      table_report_type r;
      int pos;
      int at;
      longint sx, sv, sxx, den, c, icpt, lim;
      logic signed [127:0] num, q;
      bit up, down;
      r = '{default: '0};
      r.status = STAT_OK;
      if (kind == 1'b0) begin
         if (val == int'(MISSING_MARK)) begin
            r.status = STAT_MISSING;
         end else if (find_year(yr) >= 0) begin
            r.status = STAT_DUP;
         end else if (shadow_count >= DEPTH) begin
            r.status = STAT_FULL;
         end else begin
            at = 0;
            while (at < shadow_count && shadow_years[at] < yr) at++;
            for (int i = shadow_count; i > at; i--) begin
               shadow_years[i] = shadow_years[i-1];
               shadow_values[i] = shadow_values[i-1];
            end
            shadow_years[at] = yr;
            shadow_values[at] = val;
            shadow_count++;
         end
      end else begin
         pos = find_year(yr);
         if (pos < 0) begin
            r.status = STAT_NOT_FOUND;
         end else if (val == int'(MISSING_MARK)) begin
            for (int i = pos; i + 1 < shadow_count; i++) begin
               shadow_years[i] = shadow_years[i+1];
               shadow_values[i] = shadow_values[i+1];
            end
            shadow_count--;
         end else begin
            shadow_values[pos] = val;
         end
      end
      r.entry_count = shadow_count[6:0];
      if (shadow_count > 0) begin
         sx = 0;
         sv = 0;
         sxx = 0;
         up = 1;
         down = 1;
         for (int i = 0; i < shadow_count; i++) begin
            sx += longint'(shadow_years[i]);
            sv += longint'(shadow_values[i]);
            sxx += longint'(shadow_years[i]) * longint'(shadow_years[i]);
            if (i > 0) begin
               if (shadow_values[i] > shadow_values[i-1]) down = 0;
               if (shadow_values[i] < shadow_values[i-1]) up = 0;
            end
         end
         r.stats_valid = 1'b1;
         r.avg_value = 32'(sv / longint'(shadow_count));
         r.is_monotone = up || down;
         den = longint'(shadow_count) * sxx - sx * sx;
         if (shadow_count >= 2 && den != 0) begin
            num = '0;
            for (int i = 0; i < shadow_count; i++) begin
               c = longint'(shadow_count) * longint'(shadow_years[i]) - sx;
               num += 128'(c * longint'(shadow_values[i]));
            end
            q = num / 128'(den);
            if (q > 128'sd2147483647) r.slope = 32'h7fff_ffff;
            else if (q < -128'sd2147483648) r.slope = 32'h8000_0000;
            else r.slope = q[31:0];
            icpt = (sv - longint'(r.slope) * sx) / longint'(shadow_count);
            lim = (longint'(1) <<< 47) - 1;
            if (icpt > lim) icpt = lim;
            if (icpt < -lim - 1) icpt = -lim - 1;
            r.intercept = icpt[47:0];
            r.fit_valid = 1'b1;
         end
      end
      if (shadow_count > fill_peak) fill_peak = shadow_count;
      status_seen[r.status]++;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("mismatch on word %0d: %s got %0d expected %0d", words_checked, what, got,
                  want);
   endtask

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send_word(bit kind, int yr, int val, bit typed = 0,
                            logic [2:0] st = STAT_OK, int cnt = 0);
      table_report_type r;
      int gap;
      @(negedge clock);
      req_chan.valid <= 1'b1;
      req_chan.kind <= kind;
      req_chan.year <= yr[15:0];
      req_chan.value <= val;
      do @(posedge clock); while (!req_chan.ready);
      r = apply_word(kind, yr, val);
      if (typed) begin
         r.status = st;
         r.entry_count = cnt[6:0];
      end
      pending_reports.push_back(r);
      words_sent++;
      gap = pick_gap();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      repeat (gap) @(negedge clock);
   endtask

   function automatic int pick_value(int style, int yr, int k, int b);
      case (style)
         0: return $urandom;
         1: return $urandom_range(0, 2000) - 1000;
         2: return yr * k + b;
         default: return b;
      endcase
   endfunction

   task automatic wait_for_drain();
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else if (hold_rsp) begin
         hold_rsp = 0;
         stall_left = HOLD_CYCLES;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
         stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      table_report_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_reports.size() == 0) begin
            report_mismatch("unexpected word, status", rsp_chan.status, 0);
         end else begin
            want = pending_reports.pop_front();
            if (rsp_chan.status !== want.status)
               report_mismatch("status", rsp_chan.status, want.status);
            if (rsp_chan.entry_count !== want.entry_count)
               report_mismatch("entry_count", rsp_chan.entry_count, want.entry_count);
            if (rsp_chan.stats_valid !== want.stats_valid)
               report_mismatch("stats_valid", rsp_chan.stats_valid, want.stats_valid);
            if (rsp_chan.avg_value !== want.avg_value)
               report_mismatch("avg_value", rsp_chan.avg_value, want.avg_value);
            if (rsp_chan.is_monotone !== want.is_monotone)
               report_mismatch("is_monotone", rsp_chan.is_monotone, want.is_monotone);
            if (rsp_chan.fit_valid !== want.fit_valid)
               report_mismatch("fit_valid", rsp_chan.fit_valid, want.fit_valid);
            if (rsp_chan.slope !== want.slope)
               report_mismatch("slope", rsp_chan.slope, want.slope);
            if (rsp_chan.intercept !== want.intercept)
               report_mismatch("intercept", rsp_chan.intercept, want.intercept);
         end
         words_checked++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog expired after %0d idle cycles", idle_cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      int round_no, target, style, k, b, yr, val, roll;
      clock = 1'b0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.kind = 1'b0;
      req_chan.year = '0;
      req_chan.value = '0;
      rsp_chan.ready = 1'b0;
      shadow_count = 0;
      hold_rsp = 0;
      stall_left = 0;
      idle_cycles = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i])
         send_word(stim_rows[i].kind, stim_rows[i].year, stim_rows[i].value,
                   stim_rows[i].typed, stim_rows[i].status, stim_rows[i].entry_count);
      wait_for_drain();

      round_no = 0;
      while (words_sent < ITEM_TARGET) begin
         style = $urandom_range(0, 3);
         k = $urandom_range(0, 100) - 50;
         b = $urandom;
         if (style == 2) b = $urandom_range(0, 4000000) - 2000000;
         if (b == int'(MISSING_MARK)) b = 0;
         target = ($urandom_range(0, 3) == 0) ? DEPTH : $urandom_range(2, 20);
         if (round_no == 2) hold_rsp = 1;
         while (shadow_count < target) begin
            yr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                              : $urandom_range(0, 255) * 97;
            send_word(0, yr, pick_value(style, yr, k, b));
         end
         if (shadow_count == DEPTH)
            repeat (3) send_word(0, $urandom_range(0, 65535), $urandom);
         repeat (20) begin
            roll = $urandom_range(0, 99);
            if (roll < 40 && shadow_count > 0) begin
               yr = shadow_years[$urandom_range(0, shadow_count - 1)];
               val = ($urandom_range(0, 4) == 0) ? int'(MISSING_MARK)
                                                 : pick_value(style, yr, k, b);
               send_word(1, yr, val);
            end else if (roll < 70) begin
               yr = $urandom_range(0, 65535);
               send_word(0, yr, pick_value(style, yr, k, b));
            end else if (roll < 80 && shadow_count > 0) begin
               send_word(0, shadow_years[$urandom_range(0, shadow_count - 1)], $urandom);
            end else if (roll < 85) begin
               send_word($urandom_range(0, 1), $urandom_range(0, 65535), int'(MISSING_MARK));
            end else begin
               send_word($urandom_range(0, 1), $urandom_range(0, 65535), $urandom);
            end
         end
         if ($urandom_range(0, 2) == 0)
            while (shadow_count > 0)
               send_word(1, shadow_years[$urandom_range(0, shadow_count - 1)],
                         int'(MISSING_MARK));
         if ($urandom_range(0, 3) == 0) wait_for_drain();
         round_no++;
      end
      @(negedge clock);
      req_chan.valid <= 1'b0;

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d words in %0d rounds, checked %0d, peak fill %0d of %0d", words_sent,
               round_no, words_checked, fill_peak, DEPTH);
      $display("status counts ok %0d missing %0d dup %0d not found %0d full %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3],
               status_seen[4]);
      if (mismatch_count == 0 && pending_reports.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
